FILE: rtl/pbo_pkg.sv
// types, constants and bit-serial divider helpers for the polyblep oscillator
`default_nettype none
package pbo_pkg;

   localparam int STEP_W   = 24;
   localparam int SAMPLE_W = 16;
   localparam int Q_W      = 32;
   localparam int QUO_W    = 30;
   localparam int SQ_W     = QUO_W + 1;
   localparam int SUM_W    = 34;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [Q_W:0]   ONE_Q32     = 33'h1_0000_0000;
   localparam logic [Q_W-1:0] HALF_Q32    = 32'h8000_0000;
   localparam logic [SQ_W-1:0] ONE_Q30    = 31'h4000_0000;
   localparam logic signed [SUM_W-1:0] ONE_V   = 34'sd1073741824;
   localparam logic signed [SUM_W-1:0] ROUND_V = 34'sd65536;

   typedef enum logic [1:0] {
      WAVE_SAW,
      WAVE_SQUARE,
      WAVE_TRIANGLE,
      WAVE_PULSE
   } wave_type;

   typedef enum logic [1:0] {
      BLEP_NONE,
      BLEP_NEG,
      BLEP_POS
   } blep_kind_type;

   typedef struct packed {
      blep_kind_type     kind;
      logic [Q_W-1:0]    rem;
      logic [QUO_W-1:0]  quo;
   } lane_type;

   // pick the numerator of the residual for phase q, or none
   function automatic lane_type blep_setup(input logic [Q_W-1:0] q,
                                           input logic [Q_W-1:0] dt);
      lane_type     l;
      logic [Q_W:0] rest;
      rest   = ONE_Q32 - {1'b0, q};
      l.kind = BLEP_NONE;
      l.rem  = '0;
      l.quo  = '0;
      if (dt != '0) begin
         if (q < dt) begin
            l.kind = BLEP_NEG;
            l.rem  = q;
         end else if (rest < {1'b0, dt}) begin
            l.kind = BLEP_POS;
            l.rem  = rest[Q_W-1:0];
         end
      end
      return l;
   endfunction

   // one restoring division step, one quotient bit
   function automatic lane_type div_step(input lane_type lane,
                                         input logic [Q_W-1:0] dt);
      lane_type     l;
      logic [Q_W:0] r2;
      logic         qbit;
      l    = lane;
      r2   = {lane.rem, 1'b0};
      qbit = 1'b0;
      if (r2 >= {1'b0, dt}) begin
         r2   = r2 - {1'b0, dt};
         qbit = 1'b1;
      end
      l.rem = r2[Q_W-1:0];
      l.quo = {lane.quo[QUO_W-2:0], qbit};
      return l;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/polyblep_oscillator_unit.sv
// polyblep oscillator: phase accumulator, two bit-serial residual dividers, output register
// a taken word passes setup, the 30-step restoring divider (one quotient bit per cycle),
// the shared-multiplier states MUL_A and MUL_B, sum and round before rsp_tvalid rises
// a new word is taken only in idle; round waits while the result register is not yet taken
// the result register holds a finished sample while the next word is taken in
// reset (synchronous, active high) clears the phase, wave select and handshake state
`default_nettype none
module polyblep_oscillator_unit
   import pbo_pkg::*;
#(
   parameter int PHASE_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [STEP_W-1:0]     req_tdata,   // [23:0] phase_step
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]        rsp_tdata,   // [15:0] sample_out
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_data     // [1:0] wave_select
);

   localparam int UP_SHIFT   = (PHASE_BITS >= STEP_W) ? PHASE_BITS - STEP_W : 0;
   localparam int DOWN_SHIFT = (PHASE_BITS >= STEP_W) ? 0 : STEP_W - PHASE_BITS;
   localparam int Q32_SHIFT  = Q_W - PHASE_BITS;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUM,
      ST_ROUND
   } state_type;

   state_type               state_ff, state_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [Q_W-1:0]          dt_ff, dt_in;
   wave_type                wave_ff, wave_in;
   lane_type                lane_a_ff, lane_a_in, lane_b_ff, lane_b_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SQ_W-1:0]         sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   logic signed [SUM_W-1:0] v_ff, v_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [PHASE_BITS-1:0]   step_pb;
   logic [Q_W-1:0]          step_q32;
   logic [Q_W-1:0]          p32;
   logic [SQ_W-1:0]         om_a, om_b, mul_op;
   logic [2*SQ_W-1:0]       product;
   logic signed [SUM_W-1:0] res_a, res_b;
   logic [Q_W-1:0]          tri_d;
   logic signed [SUM_W-1:0] rounded;
   logic signed [SAMPLE_W:0] r17;
   logic [SAMPLE_W-1:0]     sat;

   generate
      if (PHASE_BITS >= STEP_W) begin : g_step_up
         assign step_pb = PHASE_BITS'(req_tdata) << UP_SHIFT;
      end else begin : g_step_down
         assign step_pb = PHASE_BITS'(req_tdata >> DOWN_SHIFT);
      end
   endgenerate

   assign step_q32 = Q_W'(step_pb) << Q32_SHIFT;
   assign p32      = Q_W'(phase_ff) << Q32_SHIFT;

   // 1 - u for each lane, squared on one shared multiplier
   assign om_a    = ONE_Q30 - SQ_W'(lane_a_ff.quo);
   assign om_b    = ONE_Q30 - SQ_W'(lane_b_ff.quo);
   assign mul_op  = (state_ff == ST_MUL_A) ? om_a : om_b;
   assign product = (2*SQ_W)'(mul_op) * (2*SQ_W)'(mul_op);

   always_comb begin
      case (lane_a_ff.kind)
         BLEP_NEG: res_a = -$signed(SUM_W'(sq_a_ff));
         BLEP_POS: res_a = $signed(SUM_W'(sq_a_ff));
         default:  res_a = '0;
      endcase
      case (lane_b_ff.kind)
         BLEP_NEG: res_b = -$signed(SUM_W'(sq_b_ff));
         BLEP_POS: res_b = $signed(SUM_W'(sq_b_ff));
         default:  res_b = '0;
      endcase
   end

   assign tri_d   = p32[Q_W-1] ? p32 - HALF_Q32 : HALF_Q32 - p32;
   assign rounded = v_ff + ROUND_V;
   assign r17     = rounded[SUM_W-1:SUM_W-SAMPLE_W-1];
   assign sat     = (r17[SAMPLE_W] != r17[SAMPLE_W-1])
                  ? (r17[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_W-1){1'b1}}})
                  : r17[SAMPLE_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      dt_in        = dt_ff;
      wave_in      = wave_ff;
      lane_a_in    = lane_a_ff;
      lane_b_in    = lane_b_ff;
      cnt_in       = cnt_ff;
      sq_a_in      = sq_a_ff;
      sq_b_in      = sq_b_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         wave_in = wave_type'(csr_data);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               phase_in = phase_ff + step_pb;
               dt_in    = (step_q32 > HALF_Q32) ? HALF_Q32 : step_q32;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            lane_a_in = blep_setup(p32, dt_ff);
            // second lane sees the phase shifted by one half
            lane_b_in = blep_setup({~p32[Q_W-1], p32[Q_W-2:0]}, dt_ff);
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            lane_a_in = div_step(lane_a_ff, dt_ff);
            lane_b_in = div_step(lane_b_ff, dt_ff);
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            sq_a_in  = product[2*SQ_W-2:QUO_W];
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            sq_b_in  = product[2*SQ_W-2:QUO_W];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            unique case (wave_ff)
               WAVE_SAW:
                  v_in = $signed(SUM_W'(p32[Q_W-1:1])) - ONE_V - res_a;
               WAVE_SQUARE:
                  v_in = (p32[Q_W-1] ? -ONE_V : ONE_V) + res_a - res_b;
               WAVE_TRIANGLE:
                  v_in = ONE_V - $signed(SUM_W'(tri_d));
               WAVE_PULSE:
                  v_in = (p32[Q_W-1:Q_W-2] == 2'b00) ? ONE_V : -ONE_V;
            endcase
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = sat;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      lane_a_ff   <= lane_a_in;
      lane_b_ff   <= lane_b_in;
      sq_a_ff     <= sq_a_in;
      sq_b_ff     <= sq_b_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         wave_ff      <= WAVE_SAW;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         wave_ff      <= wave_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // a taken word always starts the residual setup next
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SETUP))
      else $error("accepted word did not start setup");

   // after the division the partial remainders stay below the step
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_A && dt_ff != '0) |->
      (lane_a_ff.rem < dt_ff && lane_b_ff.rem < dt_ff))
      else $error("divider remainder not below divisor");

   // with a nonzero step a lane without residual keeps a zero quotient
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_A && dt_ff != '0 && lane_a_ff.kind == BLEP_NONE) |->
      (lane_a_ff.quo == '0))
      else $error("quotient on a lane with no residual");

   // squared residuals never exceed one
   a_sq_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (sq_a_ff <= ONE_Q30 && sq_b_ff <= ONE_Q30))
      else $error("residual magnitude above one");

   // a waiting sample is never overwritten by the round step
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rsp_valid_ff && !rsp_tready) |=>
      (state_ff == ST_ROUND && $stable(rsp_data_ff)))
      else $error("pending sample overwritten");
`endif

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench for the polyblep oscillator unit: scoreboard with predictor, stream drivers
`default_nettype none
module testbench
   import pbo_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     RESET_CYCLES   = 12;
   localparam int     DRAIN_CYCLES   = 40;
   localparam int     HOLD_CYCLES    = 400;
   localparam int     HOLD_AFTER     = 150;
   localparam int     RANDOM_PER_SET = 172;
   localparam longint CYCLE_LIMIT    = 2_000_000;

   // predicts one sample per accepted step word and checks the sample stream in order
   class sample_scoreboard;
      localparam longint UNIT_Q30 = 64'sd1 << 30;
      localparam longint unsigned HALF_Q32_C    = 64'd1 << 31;
      localparam longint unsigned QUARTER_Q32_C = 64'd1 << 30;
      localparam longint unsigned CYCLE_Q32     = 64'd1 << 32;

      logic [STEP_W-1:0]   phase_acc;
      wave_type            wave;
      logic [SAMPLE_W-1:0] expected_samples[$];
      int                  errors;
      int                  samples_checked;

      function new();
         phase_acc       = '0;
         wave            = WAVE_SAW;
         errors          = 0;
         samples_checked = 0;
      endfunction

      function void set_wave(wave_type w);
         wave = w;
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      // polyblep correction in Q.30 for phase p and residual step dt, both Q0.32
      function longint residual_q30(longint unsigned p, longint unsigned dt);
         longint unsigned frac;
         longint unsigned sq;
         if (dt == 0) return 0;
         if (p < dt) begin
            frac = (64'd1 << 30) - (p << 30) / dt;
            sq   = (frac * frac) >> 30;
            return -longint'(sq);
         end
         if (CYCLE_Q32 - p < dt) begin
            frac = (64'd1 << 30) - ((CYCLE_Q32 - p) << 30) / dt;
            sq   = (frac * frac) >> 30;
            return longint'(sq);
         end
         return 0;
      endfunction

      function logic [SAMPLE_W-1:0] predict_sample(logic [STEP_W-1:0] step);
         longint unsigned p;
         longint unsigned dt;
         longint unsigned d;
         longint          v;
         longint          r;
         p  = 64'({phase_acc, 8'h00});
         dt = 64'({step, 8'h00});
         // steps above one half still advance in full, only the residual saturates
         if (dt > HALF_Q32_C) dt = HALF_Q32_C;
         case (wave)
            WAVE_SQUARE: begin
               v = (p < HALF_Q32_C) ? UNIT_Q30 : -UNIT_Q30;
               v = v + residual_q30(p, dt);
               v = v - residual_q30((p + HALF_Q32_C) & (CYCLE_Q32 - 1), dt);
            end
            WAVE_TRIANGLE: begin
               d = (p >= HALF_Q32_C) ? p - HALF_Q32_C : HALF_Q32_C - p;
               v = UNIT_Q30 - longint'(d);
            end
            WAVE_PULSE: begin
               v = (p < QUARTER_Q32_C) ? UNIT_Q30 : -UNIT_Q30;
            end
            default: begin
               v = longint'(p >> 1) - UNIT_Q30 - residual_q30(p, dt);
            end
         endcase
         // q.30 to q.13, halves rounded up
         r = (v + 65536) >>> 17;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return r[SAMPLE_W-1:0];
      endfunction

      function void note_step(logic [STEP_W-1:0] step);
         // the phase moves first, the sample comes from the new phase
         phase_acc = phase_acc + step;
         expected_samples.push_back(predict_sample(step));
      endfunction

      function void check_sample(logic [SAMPLE_W-1:0] got);
         logic [SAMPLE_W-1:0] want;
         samples_checked++;
         if (expected_samples.size() == 0) begin
            errors++;
            $display("%0t: unexpected sample, expected none, got %0d", $time,
                     $signed(got));
            return;
         end
         want = expected_samples.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: sample mismatch, expected %0d, got %0d", $time,
                     $signed(want), $signed(got));
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [STEP_W-1:0]   req_tdata;     // [23:0] phase_step
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [SAMPLE_W-1:0] rsp_tdata;     // [15:0] sample_out
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_data;

   sample_scoreboard sb = new();
   longint           cycle_count = 0;

   polyblep_oscillator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // every handshake is observed at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_wave(wave_type'(csr_data));
         if (req_tvalid && req_tready) sb.note_step(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_sample(rsp_tdata);
      end
   end

   // mostly no gap, some short ones, a few long
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return 0;
      if (pick < 95) return $urandom_range(4, 1);
      return $urandom_range(100, 20);
   endfunction

   function automatic logic [STEP_W-1:0] random_step();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5) return '0;
      if (pick < 20) return STEP_W'($urandom_range(24'h00FFFF, 1));
      if (pick < 70) return STEP_W'($urandom_range(24'h3FFFFF, 24'h040000));
      if (pick < 90) return STEP_W'($urandom_range(24'h800000, 24'h400000));
      if (pick < 97) return STEP_W'($urandom());
      return (pick[0]) ? 24'h800000 : 24'h7FFFFF;
   endfunction

   task automatic send_step(input logic [STEP_W-1:0] step, input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = step;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait for every predicted sample
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_wave(input wave_type w);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = w;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // receiver: random stalls, plus one long hold-off once the stream is running
   initial begin : response_sink
      int unsigned stall_left;
      bit          held;
      stall_left = 0;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sb.samples_checked >= HOLD_AFTER) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            stall_left = idle_length();
            rsp_tready = (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   initial begin : stimulus
      logic [STEP_W-1:0] edge_steps[6];
      wave_type          wave_plan[8];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = WAVE_SAW;
      // zero step first: no residual at phase zero
      edge_steps = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                     24'h400000};
      wave_plan  = '{WAVE_SAW, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_PULSE, WAVE_SQUARE,
                     WAVE_SAW, WAVE_PULSE, WAVE_TRIANGLE};
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      for (int w = 0; w < 4; w++) begin
         write_wave(wave_type'(w));
         foreach (edge_steps[i]) send_step(edge_steps[i], 0);
         drain();
      end

      foreach (wave_plan[k]) begin
         write_wave(wave_plan[k]);
         repeat (RANDOM_PER_SET) send_step(random_step(), idle_length());
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d samples never arrived, expected %0d, got none", $time,
                  sb.pending(), $signed(sb.expected_samples[0]));
      end
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
rtl/pbo_pkg.sv
rtl/polyblep_oscillator_unit.sv
dv/testbench.sv
